// ===== design/assert_macros.svh =====
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/nmea_td_pkg.sv =====
// types, constants and helpers for the nmea time and date extractor
package nmea_td_pkg;

   localparam int HistDepth  = 10;
   localparam int DigitCount = 6;

   localparam logic [7:0] Comma     = 8'h2C;
   localparam logic [7:0] Dot       = 8'h2E;
   localparam logic [7:0] DigitZero = 8'h30;

   localparam logic [3:0] MaxComma      = 4'd15;
   localparam logic [3:0] TimeCommaPrev = 4'd1;
   localparam logic [3:0] DateCommaPrev = 4'd9;

   localparam logic [6:0] MaxPos      = 7'd127;
   localparam logic [6:0] TimeNearPos = 7'd10;
   localparam logic [6:0] TimeFarPos  = 7'd11;
   localparam logic [6:0] DateBadPos  = 7'd6;

   typedef struct packed {
      logic [7:0] sentence_byte;
      logic       first_byte;
      logic       last_byte;
      logic       cmd;
   } req_type;

   typedef struct packed {
      logic [7:0] hour_code;
      logic [7:0] minute_code;
      logic [7:0] second_code;
      logic [7:0] day_code;
      logic [7:0] month_code;
      logic [7:0] year_code;
      logic       time_taken;
      logic       date_taken;
   } rsp_type;

   typedef logic [DigitCount-1:0][7:0] digits_type;

   typedef struct packed {
      digits_type time_digits;
      digits_type date_digits;
      logic       time_seen;
      logic       date_seen;
   } snap_type;

   function automatic logic [7:0] pair_code(input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] h;
      logic [7:0] l;
      h = hi - DigitZero;
      l = lo - DigitZero;
      return {h[3:0], 4'b0000} + l;
   endfunction

endpackage

// ===== design/nmea_td_input_reg.sv =====
// input register holding one request ahead of the parser
`include "assert_macros.svh"

module nmea_td_input_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  nmea_td_pkg::req_type req_data,
   input  logic                 hold,
   output logic                 step,
   output nmea_td_pkg::req_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   nmea_td_pkg::req_type data_ff;
   logic                 accept;

   assign step      = valid_ff && !hold;
   assign req_stall = valid_ff && hold;
   assign accept    = req_valid && !req_stall;
   assign item      = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   `ASSERT_IMPLIES(a_no_overrun, clock, reset, accept, !valid_ff || step)
   `ASSERT_NEXT(a_held_item_stays, clock, reset, valid_ff && hold, valid_ff)

endmodule

// ===== design/nmea_td_parser.sv =====
// sentence state: history, comma count, position and latched digits
`include "assert_macros.svh"

module nmea_td_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  nmea_td_pkg::req_type  item,
   output nmea_td_pkg::snap_type snap
);

   logic [nmea_td_pkg::HistDepth-1:0][7:0] hist_ff, hist_in, hist_cur;
   logic [3:0]                             count_ff, count_in, count_cur;
   logic [6:0]                             pos_ff, pos_in, pos_cur;
   logic                                   mode_ff, mode_in, mode_cur;
   nmea_td_pkg::digits_type                time_ff, time_in;
   nmea_td_pkg::digits_type                date_ff, date_in;
   logic                                   tseen_ff, tseen_in, tseen_cur;
   logic                                   dseen_ff, dseen_in, dseen_cur;
   logic                                   is_comma;

   always_comb begin
      if (item.first_byte) begin
         hist_cur  = '0;
         count_cur = '0;
         pos_cur   = '0;
         mode_cur  = item.cmd;
         tseen_cur = 1'b0;
         dseen_cur = 1'b0;
      end else begin
         hist_cur  = hist_ff;
         count_cur = count_ff;
         pos_cur   = pos_ff;
         mode_cur  = mode_ff;
         tseen_cur = tseen_ff;
         dseen_cur = dseen_ff;
      end

      is_comma = (item.sentence_byte == nmea_td_pkg::Comma)
                 && (count_cur != nmea_td_pkg::MaxComma);

      time_in  = time_ff;
      date_in  = date_ff;
      tseen_in = tseen_cur;
      dseen_in = dseen_cur;
      count_in = is_comma ? count_cur + 4'd1 : count_cur;

      if (is_comma && count_cur == nmea_td_pkg::TimeCommaPrev) begin
         if (hist_cur[2] == nmea_td_pkg::Dot) begin
            if (pos_cur >= nmea_td_pkg::TimeNearPos) begin
               for (int i = 0; i < nmea_td_pkg::DigitCount; i++) begin
                  time_in[i] = hist_cur[nmea_td_pkg::HistDepth-2-i];
               end
               tseen_in = 1'b1;
            end
         end else if (hist_cur[3] == nmea_td_pkg::Dot) begin
            if (pos_cur >= nmea_td_pkg::TimeFarPos) begin
               for (int i = 0; i < nmea_td_pkg::DigitCount; i++) begin
                  time_in[i] = hist_cur[nmea_td_pkg::HistDepth-1-i];
               end
               tseen_in = 1'b1;
            end
         end
      end else if (is_comma && count_cur == nmea_td_pkg::DateCommaPrev && mode_cur) begin
         if (hist_cur[0] != nmea_td_pkg::Comma && pos_cur != nmea_td_pkg::DateBadPos) begin
            for (int i = 0; i < nmea_td_pkg::DigitCount; i++) begin
               date_in[i] = hist_cur[nmea_td_pkg::DigitCount-1-i];
            end
            dseen_in = 1'b1;
         end
      end

      hist_in = {hist_cur[nmea_td_pkg::HistDepth-2:0], item.sentence_byte};
      pos_in  = (pos_cur == nmea_td_pkg::MaxPos) ? pos_cur : pos_cur + 7'd1;
      mode_in = mode_cur;
   end

   assign snap.time_digits = time_in;
   assign snap.date_digits = date_in;
   assign snap.time_seen   = tseen_in;
   assign snap.date_seen   = dseen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         mode_ff  <= 1'b0;
         time_ff  <= '0;
         date_ff  <= '0;
         tseen_ff <= 1'b0;
         dseen_ff <= 1'b0;
      end else if (step) begin
         hist_ff  <= hist_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         mode_ff  <= mode_in;
         time_ff  <= time_in;
         date_ff  <= date_in;
         tseen_ff <= tseen_in;
         dseen_ff <= dseen_in;
      end
   end

   `ASSERT_NEXT(a_pos_saturates, clock, reset,
      step && !item.first_byte && pos_ff == nmea_td_pkg::MaxPos,
      pos_ff == nmea_td_pkg::MaxPos)

endmodule

// ===== design/nmea_td_output.sv =====
// result register with digit-pair encoding
`include "assert_macros.svh"

module nmea_td_output (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  nmea_td_pkg::snap_type snap,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nmea_td_pkg::rsp_type  rsp_data
);

   logic                 valid_ff;
   logic                 valid_in;
   nmea_td_pkg::rsp_type data_ff;
   nmea_td_pkg::rsp_type data_in;

   always_comb begin
      data_in.hour_code   = nmea_td_pkg::pair_code(snap.time_digits[0], snap.time_digits[1]);
      data_in.minute_code = nmea_td_pkg::pair_code(snap.time_digits[2], snap.time_digits[3]);
      data_in.second_code = nmea_td_pkg::pair_code(snap.time_digits[4], snap.time_digits[5]);
      data_in.day_code    = nmea_td_pkg::pair_code(snap.date_digits[0], snap.date_digits[1]);
      data_in.month_code  = nmea_td_pkg::pair_code(snap.date_digits[2], snap.date_digits[3]);
      data_in.year_code   = nmea_td_pkg::pair_code(snap.date_digits[4], snap.date_digits[5]);
      data_in.time_taken  = snap.time_seen;
      data_in.date_taken  = snap.date_seen;
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, load, !(valid_ff && rsp_stall))
   `ASSERT_NEXT(a_valid_after_load, clock, reset, load, valid_ff)

endmodule

// ===== design/nmea_time_date_extractor_top.sv =====
// a request is registered in the input register, then parsed; a last-byte result is registered in the output register
// throughput: one request per cycle unless a last-byte request is held, set by the single-pass parser update
// a last-byte request waits in the input register while an earlier result is stalled
// reset is synchronous and active high; history, counters and digits clear to zero
// the first byte of a sentence clears history, counts and flags before it is parsed
module nmea_time_date_extractor_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  nmea_td_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output nmea_td_pkg::rsp_type rsp_data
);

   nmea_td_pkg::req_type  item;
   nmea_td_pkg::snap_type snap;
   logic                  step;
   logic                  hold;

   assign hold = item.last_byte && rsp_valid && rsp_stall;

   nmea_td_input_reg u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .hold      (hold),
      .step      (step),
      .item      (item)
   );

   nmea_td_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item),
      .snap  (snap)
   );

   nmea_td_output u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (step && item.last_byte),
      .snap      (snap),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
